### rtl/core/ssa_pkg.sv
`default_nettype none

package ssa_pkg;

  localparam int DataW     = 24;
  localparam int CountW    = 11;
  localparam int SumW      = 34;
  localparam int SqW       = 57;
  localparam int SquareW   = 47;
  localparam int StatusW   = 2;
  localparam int StdW      = 29;
  localparam int SvW       = 2 * StdW;
  localparam int DivW      = 68;
  localparam int RemW      = 11;
  localparam int CntW      = 7;
  localparam int FifoDepth = 4;
  localparam int PtrW      = 2;

  localparam logic [StatusW-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_DROPPED = 2'd2;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_ACC_LAST,
    OP_CLOSE
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] sample;
    logic [SquareW-1:0]      square;
  } item_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_PREP,
    ST_MEAN,
    ST_SQUARE,
    ST_DIVSQ,
    ST_SSD,
    ST_DIVVAR,
    ST_SQRT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

### rtl/core/ssa_if.sv
`default_nettype none

interface ssa_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [ssa_pkg::DataW-1:0] sample;
  logic                             sample_present;
  logic                             last;

  modport source(output valid, sample, sample_present, last, input ready);
  modport sink(input valid, sample, sample_present, last, output ready);
endinterface

interface ssa_out_if;
  logic                               valid;
  logic                               ready;
  logic [ssa_pkg::StatusW-1:0]        status;
  logic [ssa_pkg::CountW-1:0]         count;
  logic signed [ssa_pkg::DataW-1:0]   minimum;
  logic signed [ssa_pkg::DataW-1:0]   maximum;
  logic signed [ssa_pkg::DataW-1:0]   mean;
  logic [ssa_pkg::SqW-1:0]            sum_sq_dev;
  logic [ssa_pkg::SqW-1:0]            variance;
  logic [ssa_pkg::StdW-1:0]           std_dev;

  modport source(output valid, status, count, minimum, maximum, mean, sum_sq_dev,
                 variance, std_dev, input ready);
  modport sink(input valid, status, count, minimum, maximum, mean, sum_sq_dev,
               variance, std_dev, output ready);
endinterface

`default_nettype wire

### rtl/core/sample_statistics_accumulator.sv
// a sample beat passes the registered input stage and the queue and is folded in on its pop
// a last beat starts up to three 68-step restoring divides, a 34-step shift-add square and
// a 29-step square root on one shared sequencer in the back end; empty sets skip them
// throughput: one sample beat per cycle between sets; the input side keeps filling the queue
// while the back end finishes a set and holds its result, until the queue is full
// reset: asynchronous active low, clears all accumulators, queue and control state
`default_nettype none

module sample_statistics_accumulator #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssa_in_if.sink    in_i,
  ssa_out_if.source out_o
);

  logic           front_valid;
  ssa_pkg::item_t front_item;
  logic           front_ready;
  logic           q_valid;
  ssa_pkg::item_t q_item;
  logic           q_ready;

  ssa_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .item_valid_o(front_valid),
    .item_o      (front_item),
    .item_ready_i(front_ready)
  );

  ssa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_item_i (front_item),
    .push_ready_o(front_ready),
    .pop_valid_o (q_valid),
    .pop_item_o  (q_item),
    .pop_ready_i (q_ready)
  );

  ssa_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_i      (q_item),
    .item_ready_o(q_ready),
    .out_o       (out_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.count <= ssa_pkg::CountW'(MAX_SAMPLES))
    else $error("count above capacity");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.status == ssa_pkg::STATUS_EMPTY) == (out_o.count == '0)))
    else $error("empty status does not match count");

  a_var_le_ssd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.variance <= out_o.sum_sq_dev)
    else $error("variance above sum of squared deviations");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.count != '0 |-> out_o.minimum <= out_o.maximum)
    else $error("minimum above maximum");

endmodule

`default_nettype wire

### rtl/core/ssa_front.sv
`default_nettype none

module ssa_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ssa_in_if.sink              in_i,
  output logic                item_valid_o,
  output ssa_pkg::item_t      item_o,
  input  wire logic           item_ready_i
);

  localparam int Pad = ssa_pkg::DataW - SAMPLE_BITS;

  logic signed [ssa_pkg::DataW-1:0]   shifted;
  logic signed [ssa_pkg::DataW-1:0]   sext;
  logic signed [2*ssa_pkg::DataW-1:0] sq_full;
  logic                               keep;
  ssa_pkg::item_t                     item_d;
  ssa_pkg::item_t                     item_q;
  logic                               valid_q;

  always_comb begin
    shifted = $signed(in_i.sample << Pad);
    sext    = shifted >>> Pad;
    sq_full = sext * sext;
    keep    = in_i.sample_present || in_i.last;
    item_d.sample = sext;
    item_d.square = sq_full[ssa_pkg::SquareW-1:0];
    if (in_i.sample_present && in_i.last) begin
      item_d.op = ssa_pkg::OP_ACC_LAST;
    end else if (in_i.sample_present) begin
      item_d.op = ssa_pkg::OP_ACC;
    end else begin
      item_d.op = ssa_pkg::OP_CLOSE;
    end
  end

  assign in_i.ready   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ssa_fifo.sv
`default_nettype none

module ssa_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  input  wire ssa_pkg::item_t push_item_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output ssa_pkg::item_t      pop_item_o,
  input  wire logic           pop_ready_i
);

  ssa_pkg::item_t              mem_q [ssa_pkg::FifoDepth];
  logic [ssa_pkg::PtrW-1:0]    wr_q;
  logic [ssa_pkg::PtrW-1:0]    rd_q;
  logic [ssa_pkg::PtrW:0]      fill_q;
  logic                        push;
  logic                        pop;

  assign push_ready_o = fill_q < (ssa_pkg::PtrW+1)'(ssa_pkg::FifoDepth);
  assign pop_valid_o  = fill_q != '0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ssa_back.sv
`default_nettype none

module ssa_back #(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire ssa_pkg::item_t item_i,
  output logic                item_ready_o,
  ssa_out_if.source           out_o
);

  localparam int DataW   = ssa_pkg::DataW;
  localparam int CountW  = ssa_pkg::CountW;
  localparam int SumW    = ssa_pkg::SumW;
  localparam int SqW     = ssa_pkg::SqW;
  localparam int StdW    = ssa_pkg::StdW;
  localparam int SvW     = ssa_pkg::SvW;
  localparam int DivW    = ssa_pkg::DivW;
  localparam int RemW    = ssa_pkg::RemW;
  localparam int CntW    = ssa_pkg::CntW;

  ssa_pkg::state_e state_q, state_d;

  logic [CountW-1:0]       count_q;
  logic signed [SumW-1:0]  sum_q;
  logic [SqW-1:0]          sumsq_q;
  logic signed [DataW-1:0] min_q;
  logic signed [DataW-1:0] max_q;
  logic                    ovf_q;

  logic [DivW-1:0]  num_q;
  logic [RemW-1:0]  rem_q;
  logic [RemW-1:0]  div_q;
  logic [CntW-1:0]  cnt_q;
  logic [DivW-1:0]  prod_q;
  logic [DivW-1:0]  mcand_q;
  logic [SumW-1:0]  mplier_q;
  logic [DataW-1:0] mean_q;
  logic [SqW-1:0]   ssd_q;
  logic [SqW-1:0]   var_q;
  logic [SvW-1:0]   sv_q;
  logic [StdW-1:0]  root_q;
  logic [StdW+1:0]  srem_q;

  logic             pop;
  logic             has_room;
  logic [SumW-1:0]  abs_sum;
  logic [RemW:0]    dv_r;
  logic             dv_ge;
  logic [RemW-1:0]  rem_n;
  logic [DivW-1:0]  quo_n;
  logic [DataW-1:0] qa;
  logic [DivW-1:0]  prod_n;
  logic [DivW-1:0]  sub_full;
  logic [DivW-1:0]  sq_ext;
  logic [SqW-1:0]   ssd_d;
  logic [StdW+3:0]  sr_t;
  logic [StdW+3:0]  sr_trial;
  logic             sr_ge;
  logic             div_last;
  logic             mul_last;
  logic             rt_last;

  assign has_room = count_q < CountW'(MAX_SAMPLES);
  assign abs_sum  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign div_last = cnt_q == CntW'(DivW - 1);
  assign mul_last = cnt_q == CntW'(SumW - 1);
  assign rt_last  = cnt_q == CntW'(StdW - 1);

  // restoring divide step
  always_comb begin
    dv_r  = {rem_q, num_q[DivW-1]};
    dv_ge = dv_r >= {1'b0, div_q};
    rem_n = dv_ge ? RemW'(dv_r - {1'b0, div_q}) : dv_r[RemW-1:0];
    quo_n = {num_q[DivW-2:0], dv_ge};
    qa    = quo_n[DataW-1:0];
  end

  // shift-add multiply step and ssd
  always_comb begin
    prod_n   = prod_q + (mplier_q[0] ? mcand_q : '0);
    sub_full = num_q + DivW'(rem_q != '0);
    sq_ext   = {{(DivW-SqW){1'b0}}, sumsq_q};
    ssd_d    = (sq_ext >= sub_full) ? SqW'(sq_ext - sub_full) : '0;
  end

  // square root digit step
  always_comb begin
    sr_t     = {srem_q, sv_q[SvW-1 -: 2]};
    sr_trial = {2'b00, root_q, 2'b01};
    sr_ge    = sr_t >= sr_trial;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssa_pkg::ST_ACC: begin
        if (pop && item_i.op != ssa_pkg::OP_ACC) begin
          state_d = ssa_pkg::ST_PREP;
        end
      end
      ssa_pkg::ST_PREP:   state_d = (count_q == '0) ? ssa_pkg::ST_OUT : ssa_pkg::ST_MEAN;
      ssa_pkg::ST_MEAN:   if (div_last) state_d = ssa_pkg::ST_SQUARE;
      ssa_pkg::ST_SQUARE: if (mul_last) state_d = ssa_pkg::ST_DIVSQ;
      ssa_pkg::ST_DIVSQ:  if (div_last) state_d = ssa_pkg::ST_SSD;
      ssa_pkg::ST_SSD: begin
        state_d = (count_q > CountW'(1)) ? ssa_pkg::ST_DIVVAR : ssa_pkg::ST_SQRT;
      end
      ssa_pkg::ST_DIVVAR: if (div_last) state_d = ssa_pkg::ST_SQRT;
      ssa_pkg::ST_SQRT:   if (rt_last) state_d = ssa_pkg::ST_OUT;
      ssa_pkg::ST_OUT:    if (out_o.ready) state_d = ssa_pkg::ST_ACC;
      default:            state_d = ssa_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    item_ready_o = 1'b0;
    out_o.valid  = 1'b0;
    unique case (state_q)
      ssa_pkg::ST_ACC: item_ready_o = 1'b1;
      ssa_pkg::ST_OUT: out_o.valid  = 1'b1;
      default: begin
        item_ready_o = 1'b0;
        out_o.valid  = 1'b0;
      end
    endcase
  end

  assign pop = item_valid_i && item_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssa_pkg::ST_ACC;
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (pop && item_i.op != ssa_pkg::OP_CLOSE) begin
        if (has_room) begin
          if (count_q == '0 || item_i.sample < min_q) begin
            min_q <= item_i.sample;
          end
          if (count_q == '0 || item_i.sample > max_q) begin
            max_q <= item_i.sample;
          end
          sum_q   <= sum_q + {{(SumW-DataW){item_i.sample[DataW-1]}}, item_i.sample};
          sumsq_q <= sumsq_q + {{(SqW-ssa_pkg::SquareW){1'b0}}, item_i.square};
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (state_q == ssa_pkg::ST_OUT && out_o.ready) begin
        count_q <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
        min_q   <= '0;
        max_q   <= '0;
        ovf_q   <= 1'b0;
      end
      priority case (state_q)
        ssa_pkg::ST_PREP, ssa_pkg::ST_SSD, ssa_pkg::ST_OUT: cnt_q <= '0;
        ssa_pkg::ST_MEAN, ssa_pkg::ST_DIVSQ, ssa_pkg::ST_DIVVAR: begin
          cnt_q <= div_last ? '0 : cnt_q + 1'b1;
        end
        ssa_pkg::ST_SQUARE: cnt_q <= mul_last ? '0 : cnt_q + 1'b1;
        ssa_pkg::ST_SQRT:   cnt_q <= rt_last ? '0 : cnt_q + 1'b1;
        default:            cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ssa_pkg::ST_PREP: begin
        num_q  <= {{(DivW-SumW){1'b0}}, abs_sum};
        rem_q  <= '0;
        div_q  <= count_q;
        mean_q <= '0;
        ssd_q  <= '0;
        var_q  <= '0;
        root_q <= '0;
      end
      ssa_pkg::ST_MEAN: begin
        num_q <= quo_n;
        rem_q <= rem_n;
        if (div_last) begin
          mean_q   <= sum_q[SumW-1] ? DataW'(-qa) : qa;
          prod_q   <= '0;
          mcand_q  <= {{(DivW-SumW){1'b0}}, abs_sum};
          mplier_q <= abs_sum;
        end
      end
      ssa_pkg::ST_SQUARE: begin
        prod_q   <= prod_n;
        mcand_q  <= {mcand_q[DivW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[SumW-1:1]};
        if (mul_last) begin
          num_q <= prod_n;
          rem_q <= '0;
        end
      end
      ssa_pkg::ST_DIVSQ: begin
        num_q <= quo_n;
        rem_q <= rem_n;
      end
      ssa_pkg::ST_SSD: begin
        ssd_q  <= ssd_d;
        num_q  <= {{(DivW-SqW){1'b0}}, ssd_d};
        rem_q  <= '0;
        div_q  <= count_q - 1'b1;
        var_q  <= '0;
        sv_q   <= '0;
        root_q <= '0;
        srem_q <= '0;
      end
      ssa_pkg::ST_DIVVAR: begin
        num_q <= quo_n;
        rem_q <= rem_n;
        if (div_last) begin
          var_q  <= quo_n[SqW-1:0];
          sv_q   <= {{(SvW-SqW){1'b0}}, quo_n[SqW-1:0]};
          root_q <= '0;
          srem_q <= '0;
        end
      end
      ssa_pkg::ST_SQRT: begin
        srem_q <= sr_ge ? (StdW+2)'(sr_t - sr_trial) : sr_t[StdW+1:0];
        root_q <= {root_q[StdW-2:0], sr_ge};
        sv_q   <= {sv_q[SvW-3:0], 2'b00};
      end
      default: begin
        num_q <= num_q;
      end
    endcase
  end

  always_comb begin
    if (count_q == '0) begin
      out_o.status = ssa_pkg::STATUS_EMPTY;
    end else if (ovf_q) begin
      out_o.status = ssa_pkg::STATUS_DROPPED;
    end else begin
      out_o.status = ssa_pkg::STATUS_OK;
    end
  end

  assign out_o.count      = count_q;
  assign out_o.minimum    = min_q;
  assign out_o.maximum    = max_q;
  assign out_o.mean       = $signed(mean_q);
  assign out_o.sum_sq_dev = ssd_q;
  assign out_o.variance   = var_q;
  assign out_o.std_dev    = root_q;

endmodule

`default_nettype wire

### tb/sample_statistics_accumulator_test.sv
`default_nettype none

module sample_statistics_accumulator_test;

  localparam int MaxSamples = 1024;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [ssa_pkg::StatusW-1:0]      status;
    logic [ssa_pkg::CountW-1:0]       count;
    logic signed [ssa_pkg::DataW-1:0] minimum;
    logic signed [ssa_pkg::DataW-1:0] maximum;
    logic signed [ssa_pkg::DataW-1:0] mean;
    logic [ssa_pkg::SqW-1:0]          sum_sq_dev;
    logic [ssa_pkg::SqW-1:0]          variance;
    logic [ssa_pkg::StdW-1:0]         std_dev;
  } stats_t;

  typedef struct {
    logic signed [ssa_pkg::DataW-1:0] sample;
    bit                               present;
    bit                               last;
    bit                               typed;
    stats_t                           stats;
  } row_t;

  logic clk_i;
  logic rst_ni;
  ssa_in_if  in_bus();
  ssa_out_if out_bus();

  sample_statistics_accumulator DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  longint unsigned acc_count;
  longint          acc_sum;
  longint unsigned acc_sumsq;
  longint          acc_min;
  longint          acc_max;
  bit              acc_dropped;

  stats_t stats_expected[$];
  int     mismatch_count;
  bit     no_idle;
  bit     hold_off;
  bit     stim_done;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void clear_acc();
    acc_count = 0;
    acc_sum = 0;
    acc_sumsq = 0;
    acc_min = 0;
    acc_max = 0;
    acc_dropped = 0;
  endfunction

  // folds one beat in, returns 1 with the stats when the set closes
  function automatic bit fold_beat(logic signed [ssa_pkg::DataW-1:0] smp, bit present,
                                   bit last, output stats_t st);
    longint s;
    longint unsigned n, a, qa, ra, q, r, sub, ssd, vr;
    st = '0;
    if (present) begin
      if (acc_count < MaxSamples) begin
        s = smp;
        if (acc_count == 0 || s < acc_min) acc_min = s;
        if (acc_count == 0 || s > acc_max) acc_max = s;
        acc_sum += s;
        acc_sumsq += s * s;
        acc_count++;
      end else begin
        acc_dropped = 1;
      end
    end
    if (!last) return 0;
    n = acc_count;
    if (n == 0) begin
      st.status = ssa_pkg::STATUS_EMPTY;
    end else begin
      a = acc_sum < 0 ? -acc_sum : acc_sum;
      qa = a / n;
      ra = a % n;
      q = qa * qa * n + 2 * qa * ra + (ra * ra) / n;
      r = (ra * ra) % n;
      sub = q + (r != 0);
      ssd = acc_sumsq >= sub ? acc_sumsq - sub : 0;
      vr = n > 1 ? ssd / (n - 1) : 0;
      st.status = acc_dropped ? ssa_pkg::STATUS_DROPPED : ssa_pkg::STATUS_OK;
      st.count = ssa_pkg::CountW'(n);
      st.minimum = ssa_pkg::DataW'(acc_min);
      st.maximum = ssa_pkg::DataW'(acc_max);
      st.mean = ssa_pkg::DataW'(acc_sum / longint'(n));
      st.sum_sq_dev = ssa_pkg::SqW'(ssd);
      st.variance = ssa_pkg::SqW'(vr);
      st.std_dev = ssa_pkg::StdW'(floor_sqrt(vr));
    end
    clear_acc();
    return 1;
  endfunction

  function automatic bit roll_idle();
    return !no_idle && ($urandom_range(99) < 19);
  endfunction

  task automatic send_beat(row_t rw);
    stats_t st;
    bit got;
    while (roll_idle()) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.sample <= rw.sample;
    in_bus.sample_present <= rw.present;
    in_bus.last <= rw.last;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    got = fold_beat(rw.sample, rw.present, rw.last, st);
    if (got) begin
      if (rw.typed && st !== rw.stats) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("typed row disagrees: table %h predictor %h", rw.stats, st);
      end
      stats_expected.push_back(st);
    end
    @(negedge clk_i);
  endtask

  function automatic row_t mk(logic signed [ssa_pkg::DataW-1:0] smp, bit p, bit l);
    row_t rw;
    rw.sample = smp;
    rw.present = p;
    rw.last = l;
    rw.typed = 0;
    rw.stats = '0;
    return rw;
  endfunction

  function automatic row_t mk_typed(logic signed [ssa_pkg::DataW-1:0] smp, bit p, bit l,
                                    stats_t st);
    row_t rw;
    rw = mk(smp, p, l);
    rw.typed = 1;
    rw.stats = st;
    return rw;
  endfunction

  task automatic random_set(int len, bit extreme);
    logic signed [ssa_pkg::DataW-1:0] smp;
    for (int k = 0; k < len; k++) begin
      if (extreme) smp = $urandom_range(1) ? 24'sh7fffff : -24'sh800000;
      else smp = ssa_pkg::DataW'($urandom);
      send_beat(mk(smp, extreme || $urandom_range(9) != 0 || k == len - 1, k == len - 1));
    end
  endtask

  // driver
  initial begin
    row_t tbl[$];
    stats_t st;
    int sent;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample = '0;
    in_bus.sample_present = 1'b0;
    in_bus.last = 1'b0;
    no_idle = 0;
    stim_done = 0;
    mismatch_count = 0;
    clear_acc();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty set
    st = '0; st.status = ssa_pkg::STATUS_EMPTY;
    tbl.push_back(mk_typed('0, 0, 1, st));
    // no sample, not last, then a single max sample
    tbl.push_back(mk('0, 0, 0));
    st = '0; st.status = ssa_pkg::STATUS_OK; st.count = 1;
    st.minimum = 24'sh7fffff; st.maximum = 24'sh7fffff; st.mean = 24'sh7fffff;
    tbl.push_back(mk_typed(24'sh7fffff, 1, 1, st));
    st.minimum = -24'sh800000; st.maximum = -24'sh800000; st.mean = -24'sh800000;
    tbl.push_back(mk_typed(-24'sh800000, 1, 1, st));
    // both extremes, closed by an empty last
    tbl.push_back(mk(24'sh7fffff, 1, 0));
    tbl.push_back(mk(-24'sh800000, 1, 0));
    tbl.push_back(mk('0, 0, 1));
    tbl.push_back(mk(-24'sd1, 1, 0));
    tbl.push_back(mk(24'sd2, 1, 0));
    tbl.push_back(mk(24'sd0, 1, 1));
    tbl.push_back(mk(24'sh555555, 1, 0));
    tbl.push_back(mk(-24'sh2aaaab, 1, 1));
    foreach (tbl[k]) send_beat(tbl[k]);

    // capacity exceeded: max-swing set over capacity
    random_set(MaxSamples + 2, 1);

    sent = tbl.size() + MaxSamples + 2;
    while (sent < 1850) begin
      int len;
      no_idle = (sent > 1200 && sent < 1450);
      len = $urandom_range(9) == 0 ? $urandom_range(60) + 1 : $urandom_range(6) + 1;
      random_set(len, $urandom_range(19) == 0);
      sent += len;
    end
    in_bus.valid <= 1'b0;
    stim_done = 1;
  end

  // receiver
  initial begin
    int hold_len;
    out_bus.ready = 1'b0;
    hold_off = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_off && stats_expected.size() != 0 && hold_len == 0)
        begin
        hold_off = 1;
        hold_len = 2000;
      end
      if (hold_off) begin
        out_bus.ready <= 1'b0;
        hold_len--;
        if (hold_len == 0) hold_off = 0;
        hold_len = hold_off ? hold_len : -1;
      end else begin
        out_bus.ready <= !roll_idle();
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    stats_t got;
    stats_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.status = out_bus.status;
      got.count = out_bus.count;
      got.minimum = out_bus.minimum;
      got.maximum = out_bus.maximum;
      got.mean = out_bus.mean;
      got.sum_sq_dev = out_bus.sum_sq_dev;
      got.variance = out_bus.variance;
      got.std_dev = out_bus.std_dev;
      if (stats_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = stats_expected.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: status %0d/%0d count %0d/%0d min %0d/%0d max %0d/%0d",
                     want.status, got.status, want.count, got.count, want.minimum,
                     got.minimum, want.maximum, got.maximum);
            $display("  mean %0d/%0d ssd %0d/%0d var %0d/%0d sd %0d/%0d",
                     want.mean, got.mean, want.sum_sq_dev, got.sum_sq_dev,
                     want.variance, got.variance, want.std_dev, got.std_dev);
          end
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchLimit) begin
        $display("sample_statistics_accumulator regression: fail");
        $finish;
      end
      if (stim_done && stats_expected.size() == 0 && quiet >= 400) begin
        if (mismatch_count == 0) begin
          $display("sample_statistics_accumulator regression: pass");
        end else begin
          $display("sample_statistics_accumulator regression: fail");
        end
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
